// ===== sv/brb_pkg.sv =====
package brb_pkg;

  // store size; the 10-bit used count and amount fields and the 11-bit free count are sized for it
  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  localparam logic [2:0] CMD_ENQUEUE    = 3'd0;
  localparam logic [2:0] CMD_DEQUEUE    = 3'd1;
  localparam logic [2:0] CMD_PEEK       = 3'd2;
  localparam logic [2:0] CMD_MOVE_REAR  = 3'd3;
  localparam logic [2:0] CMD_MOVE_FRONT = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  // store access issued with an accepted beat
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  // result fields known at accept time; the byte follows from the store
  typedef struct packed {
    logic             ok;
    logic             rd_sel;
    logic [PTR_W-1:0] used;
    logic [CNT_W-1:0] free;
  } rslt_t;

endpackage

// ===== sv/brb_mem.sv =====
module brb_mem (
  input  logic                     clk,
  input  brb_pkg::mem_req_t        req,
  output logic [7:0]               rd_data
);

  logic [7:0] store [brb_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
  end

  // read data only moves on a read, so it holds while the result waits
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= store[req.raddr];
    end
  end

endmodule

// ===== sv/brb_ctrl.sv =====
module brb_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [2:0]                command,
  input  logic [7:0]                data_in,
  input  logic [brb_pkg::PTR_W-1:0] amount,
  output brb_pkg::mem_req_t         req,
  output brb_pkg::rslt_t            rslt
);

  logic [brb_pkg::PTR_W-1:0] read_pointer, read_pointer_next;
  logic [brb_pkg::PTR_W-1:0] write_pointer, write_pointer_next;
  logic [brb_pkg::PTR_W-1:0] used_now, used_after, wp_inc, rp_inc;
  logic                      ok;
  logic                      rd_sel;

  assign used_now = write_pointer - read_pointer;
  assign wp_inc   = write_pointer + brb_pkg::PTR_W'(1);
  assign rp_inc   = read_pointer + brb_pkg::PTR_W'(1);

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    ok                 = 1'b0;
    rd_sel             = 1'b0;
    req.we             = 1'b0;
    req.waddr          = wp_inc;
    req.wdata          = data_in;
    req.re             = 1'b0;
    req.raddr          = rp_inc;
    unique case (command)
      brb_pkg::CMD_ENQUEUE: begin
        if (wp_inc != read_pointer) begin
          write_pointer_next = wp_inc;
          req.we             = accept;
          ok                 = 1'b1;
        end
      end
      brb_pkg::CMD_DEQUEUE: begin
        if (read_pointer != write_pointer) begin
          read_pointer_next = rp_inc;
          req.re            = accept;
          rd_sel            = 1'b1;
          ok                = 1'b1;
        end
      end
      brb_pkg::CMD_PEEK: begin
        req.raddr = rp_inc + amount;
        if (amount < used_now) begin
          req.re = accept;
          rd_sel = 1'b1;
          ok     = 1'b1;
        end
      end
      brb_pkg::CMD_MOVE_REAR: begin
        write_pointer_next = write_pointer + amount;
        ok                 = 1'b1;
      end
      brb_pkg::CMD_MOVE_FRONT: begin
        read_pointer_next = read_pointer + amount;
        ok                = 1'b1;
      end
      brb_pkg::CMD_CLEAR: begin
        read_pointer_next  = '0;
        write_pointer_next = '0;
        ok                 = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign used_after  = write_pointer_next - read_pointer_next;
  assign rslt.ok     = ok;
  assign rslt.rd_sel = rd_sel;
  assign rslt.used   = used_after;
  assign rslt.free   = brb_pkg::CNT_W'(brb_pkg::DEPTH) - {1'b0, used_after};

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
    end else if (accept) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
    end
  end

endmodule

// ===== sv/byte_ring_buffer_fifo_core.sv =====
// byte ring buffer of 1024 entries with one slot kept empty, so it holds up
// to 1023 bytes. every input beat carries one command (enqueue, dequeue,
// peek at an offset from the front, move rear, move front, clear) and gives
// exactly one result beat with ok, the byte read (zero unless a dequeue or
// peek succeeds) and the used and free counts after the command. the bytes
// live in one synchronous ram with a registered read; the pointers, the
// full/empty and peek range checks and the counts are worked out in the
// cycle a beat is accepted, and the ram access issued then, so a result
// appears on the output in the cycle after its command is taken. one beat a
// cycle is sustained: a new command is taken while the previous result is
// being taken, and in_stall rises only while a finished result sits
// stalled in the output register. a write is always complete before any
// later read of the ram, so no forwarding is needed. bytes never written
// but exposed by a pointer move read back as whatever the ram holds
module byte_ring_buffer_fifo_core (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  data_in,
  input  logic [9:0]  amount,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_out,
  output logic        ok,
  output logic [9:0]  used_count,
  output logic [10:0] free_count
);

  logic              accept;
  brb_pkg::mem_req_t req;
  brb_pkg::rslt_t    rslt;
  brb_pkg::rslt_t    held;
  logic [7:0]        rd_data;

  // output register is free when empty or being drained this cycle
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  brb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .data_in (data_in),
    .amount  (amount),
    .req     (req),
    .rslt    (rslt)
  );

  brb_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, captured with the ram read
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= rslt;
    end
  end

  // byte comes straight off the ram read register, zero unless a read hit
  assign data_out   = held.rd_sel ? rd_data : 8'd0;
  assign ok         = held.ok;
  assign used_count = held.used;
  assign free_count = held.free;

  // counts always add up to the store size
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, used_count} + free_count) == 11'(brb_pkg::DEPTH))
    else $error("used and free counts disagree");

  // a refused command never returns a byte
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> data_out == 8'd0)
    else $error("refused command returned data");

  // a stalled result keeps its read byte
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(data_out))
    else $error("stalled result byte changed");

  // every accepted command shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted command gave no result");

endmodule
